// ===== hdl/crc_checked_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CCFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ccfr_pkg.sv =====
// Types, constants and the CRC byte update for the frame receiver.
`default_nettype none

package ccfr_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned FRAME_OVERHEAD  = 11;
    localparam int unsigned HEADER_BYTES    = 8;

    // Header byte positions
    localparam logic [CNT_W-1:0] POS_FIRST  = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_FUNC   = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_ADDR_H = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_ADDR_L = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_LEN_H  = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_LEN_L  = CNT_W'(7);

    localparam logic [7:0]  DEVICE_ERROR_FUNC = 8'h86;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    localparam int unsigned TDATA_W = 96;

    typedef enum logic [0:0] {
        KIND_BYTE  = 1'b0,
        KIND_CLEAR = 1'b1
    } t_in_kind;

    typedef enum logic [0:0] {
        RK_PAYLOAD = 1'b0,
        RK_VERDICT = 1'b1
    } t_res_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_HEAD = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_BAD_TAIL = 3'd3,
        ST_CRC_BAD  = 3'd4,
        ST_DEV_ERR  = 3'd5
    } t_status;

    typedef enum logic [0:0] {
        REG_HEAD = 1'b0,
        REG_TAIL = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_res_kind   result_kind;
        logic [15:0] carried_crc;
        logic [15:0] computed_crc;
        logic [15:0] data_length;
        logic [15:0] start_address;
        logic [7:0]  function_code;
        t_status     status;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
    } t_result;

    // CRC-16/MODBUS, reflected, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crc_checked_frame_receiver.sv =====
// Byte-stream frame receiver: delimits frames, streams payload, reports a CRC-checked verdict.
// One received byte is taken per clock while the skid register is empty: the CRC byte update
// and the frame counter step are combinational between the state registers and the result
// register, and each result is registered in the output register or, on a stall, the skid.
// Results go through an output register backed by a one-entry skid register; the input
// stalls only while both hold results. A clear transaction empties the frame state and keeps
// head_value (0x0) and tail_value (0x4). Frames whose length field plus 11 exceeds
// MAX_FRAME_BYTES are rejected at the eighth byte.
`default_nettype none

module crc_checked_frame_receiver
    import ccfr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // stream in
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    input  wire logic               s_axis_tuser,   // [0] kind
    // stream out
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status, [26:19] function_code,
    // [42:27] start_address, [58:43] data_length, [74:59] computed_crc,
    // [90:75] carried_crc, [95:91] zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tuser,   // [0] result_kind
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    `include "crc_checked_frame_receiver_defines.svh"

    logic [7:0]       r_head, r_tail;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [CNT_W-1:0] r_frame_len, n_frame_len;
    logic [7:0]       r_first_byte, n_first_byte;
    logic [7:0]       r_func, n_func;
    logic [15:0]      r_addr, n_addr;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_crc_hi, n_crc_hi;
    logic [7:0]       r_crc_lo, n_crc_lo;

    logic             in_acc;
    logic [7:0]       rx_b;
    logic [15:0]      crc_step;
    logic [16:0]      len_sum;
    logic [15:0]      rx_crc;
    logic [CNT_W-1:0] fl_m3, fl_m2;
    logic             do_clear;
    logic             res_vld;
    t_result          res;

    logic             r_out_vld, n_out_vld;
    logic             r_skid_vld, n_skid_vld;
    t_result          r_out, n_out;
    t_result          r_skid;
    logic             out_take;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HEAD: r_head <= pwdata[7:0];
                REG_TAIL: r_tail <= pwdata[7:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HEAD: prdata = {24'h0, r_head};
            REG_TAIL: prdata = {24'h0, r_tail};
            default:  prdata = '0;
        endcase
    end

    // ---------------- frame state ----------------
    assign s_axis_tready = ~r_skid_vld;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign rx_b          = s_axis_tdata;
    assign crc_step      = crc16_update(r_crc, rx_b);
    assign fl_m3         = r_frame_len - CNT_W'(3);
    assign fl_m2         = r_frame_len - CNT_W'(2);
    assign rx_crc        = {r_crc_hi, r_crc_lo};

    always_comb begin
        n_byte_cnt   = r_byte_cnt;
        n_frame_len  = r_frame_len;
        n_first_byte = r_first_byte;
        n_func       = r_func;
        n_addr       = r_addr;
        n_len        = r_len;
        n_crc        = r_crc;
        n_crc_hi     = r_crc_hi;
        n_crc_lo     = r_crc_lo;
        do_clear     = 1'b0;
        res_vld      = 1'b0;
        res          = '0;
        len_sum      = '0;

        if (in_acc) begin
            if (t_in_kind'(s_axis_tuser) == KIND_CLEAR) begin
                do_clear = 1'b1;
            end else if (r_frame_len == '0) begin
                // header phase
                case (r_byte_cnt)
                    POS_FIRST:  n_first_byte = rx_b;
                    POS_FUNC:   n_func       = rx_b;
                    POS_ADDR_H: n_addr       = {rx_b, r_addr[7:0]};
                    POS_ADDR_L: n_addr       = {r_addr[15:8], rx_b};
                    POS_LEN_H:  n_len        = {rx_b, r_len[7:0]};
                    POS_LEN_L:  n_len        = {r_len[15:8], rx_b};
                    default:    ;
                endcase
                n_crc      = crc_step;
                n_byte_cnt = r_byte_cnt + CNT_W'(1);
                len_sum    = {1'b0, n_len} + 17'(FRAME_OVERHEAD);
                res.function_code = n_func;
                res.start_address = n_addr;
                res.data_length   = n_len;
                res.computed_crc  = n_crc;
                res.result_kind   = RK_VERDICT;
                if (r_byte_cnt == POS_LEN_L) begin
                    if (r_first_byte != r_head) begin
                        res_vld    = 1'b1;
                        res.status = ST_BAD_HEAD;
                        do_clear   = 1'b1;
                    end else if (len_sum > 17'(MAX_FRAME_BYTES)) begin
                        res_vld    = 1'b1;
                        res.status = ST_TOO_LONG;
                        do_clear   = 1'b1;
                    end else begin
                        n_frame_len = len_sum[CNT_W-1:0];
                    end
                end
            end else begin
                n_byte_cnt        = r_byte_cnt + CNT_W'(1);
                res.function_code = r_func;
                res.start_address = r_addr;
                res.data_length   = r_len;
                if (r_byte_cnt < fl_m3) begin
                    n_crc             = crc_step;
                    res_vld           = 1'b1;
                    res.result_kind   = RK_PAYLOAD;
                    res.payload_byte  = rx_b;
                    res.payload_index = 8'(r_byte_cnt - CNT_W'(HEADER_BYTES));
                end else if (r_byte_cnt == fl_m3) begin
                    n_crc_hi = rx_b;
                end else if (r_byte_cnt == fl_m2) begin
                    n_crc_lo = rx_b;
                end else begin
                    // tail byte: tail, then CRC, then device error
                    res_vld          = 1'b1;
                    res.result_kind  = RK_VERDICT;
                    res.computed_crc = r_crc;
                    res.carried_crc  = rx_crc;
                    if (rx_b != r_tail)
                        res.status = ST_BAD_TAIL;
                    else if (r_crc != rx_crc)
                        res.status = ST_CRC_BAD;
                    else if (r_func == DEVICE_ERROR_FUNC)
                        res.status = ST_DEV_ERR;
                    else
                        res.status = ST_OK;
                    do_clear = 1'b1;
                end
            end
        end

        if (do_clear) begin
            n_byte_cnt   = '0;
            n_frame_len  = '0;
            n_first_byte = '0;
            n_func       = '0;
            n_addr       = '0;
            n_len        = '0;
            n_crc        = CRC_INIT;
            n_crc_hi     = '0;
            n_crc_lo     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt   <= '0;
            r_frame_len  <= '0;
            r_first_byte <= '0;
            r_func       <= '0;
            r_addr       <= '0;
            r_len        <= '0;
            r_crc        <= CRC_INIT;
            r_crc_hi     <= '0;
            r_crc_lo     <= '0;
        end else begin
            r_byte_cnt   <= n_byte_cnt;
            r_frame_len  <= n_frame_len;
            r_first_byte <= n_first_byte;
            r_func       <= n_func;
            r_addr       <= n_addr;
            r_len        <= n_len;
            r_crc        <= n_crc;
            r_crc_hi     <= n_crc_hi;
            r_crc_lo     <= n_crc_lo;
        end
    end

    // ---------------- output register + skid ----------------
    assign out_take = r_out_vld & m_axis_tready;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        if (!r_out_vld || out_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = res;
                n_out_vld = res_vld;
            end
        end else if (res_vld) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_out_vld && !out_take && res_vld)
            r_skid <= res;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tdata  = {5'b0, r_out.carried_crc, r_out.computed_crc, r_out.data_length,
                            r_out.start_address, r_out.function_code, r_out.status,
                            r_out.payload_index, r_out.payload_byte};

    // ---------------- assertions ----------------
    `CCFR_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid holds data while output empty")
    `CCFR_ASSERT_NOW(a_frame_len_range, r_frame_len != '0,
        (r_frame_len >= CNT_W'(FRAME_OVERHEAD)) &&
        ({1'b0, r_frame_len} <= (CNT_W+1)'(MAX_FRAME_BYTES)),
        "frame length out of range")
    `CCFR_ASSERT_NOW(a_cnt_in_frame, r_frame_len != '0, r_byte_cnt < r_frame_len,
        "byte count ran past frame end")
    `CCFR_ASSERT_NOW(a_cnt_in_header, r_frame_len == '0, r_byte_cnt < CNT_W'(HEADER_BYTES),
        "header phase ran past eighth byte")
    `CCFR_ASSERT_NEXT(a_clear_empties, in_acc && (t_in_kind'(s_axis_tuser) == KIND_CLEAR),
        (r_byte_cnt == '0) && (r_frame_len == '0) && (r_crc == CRC_INIT),
        "clear did not empty the receiver")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the CRC-checked frame receiver: random framed byte traffic, scoreboard check.
module tb;
    import ccfr_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;

    class frame_scoreboard;
        logic [7:0]  head_reg;
        logic [7:0]  tail_reg;
        int unsigned byte_count;
        int unsigned frame_len;     // 0 while the header is still coming in
        logic [7:0]  first_byte;
        logic [7:0]  func_byte;
        logic [15:0] addr_cap;
        logic [15:0] len_cap;
        logic [15:0] crc_acc;
        logic [7:0]  crc_hi;
        logic [7:0]  crc_lo;
        t_result     pending_results[$];
        int          errors;

        function new();
            head_reg = '0;
            tail_reg = '0;
            errors   = 0;
            wipe();
        endfunction

        // CRC-16/MODBUS, reflected poly 0xA001, one byte
        static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
            return r;
        endfunction

        function void wipe();
            byte_count = 0;
            frame_len  = 0;
            first_byte = '0;
            func_byte  = '0;
            addr_cap   = '0;
            len_cap    = '0;
            crc_acc    = 16'hFFFF;
            crc_hi     = '0;
            crc_lo     = '0;
        endfunction

        function void push(t_res_kind rk, logic [7:0] pb, logic [7:0] pi, t_status st,
                           logic [15:0] rcrc);
            t_result r;
            r.result_kind   = rk;
            r.payload_byte  = pb;
            r.payload_index = pi;
            r.status        = st;
            r.function_code = func_byte;
            r.start_address = addr_cap;
            r.data_length   = len_cap;
            r.computed_crc  = (rk == RK_VERDICT) ? crc_acc : 16'h0000;
            r.carried_crc   = rcrc;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void note_byte(t_in_kind k, logic [7:0] b);
            int unsigned idx;
            logic [15:0] rcrc;
            t_status     st;
            if (k == KIND_CLEAR) begin
                wipe();
                return;
            end
            idx = byte_count;
            byte_count = idx + 1;
            if (frame_len == 0) begin
                case (idx)
                    0: first_byte = b;
                    3: func_byte = b;
                    4: addr_cap[15:8] = b;
                    5: addr_cap[7:0] = b;
                    6: len_cap[15:8] = b;
                    7: len_cap[7:0] = b;
                    default: ;
                endcase
                crc_acc = crc_byte(crc_acc, b);
                if (byte_count < HEADER_BYTES) return;
                if (first_byte != head_reg) begin
                    push(RK_VERDICT, 8'h00, 8'h00, ST_BAD_HEAD, 16'h0000);
                    wipe();
                end else if (int'(len_cap) + FRAME_OVERHEAD > MAX_FRAME_BYTES) begin
                    push(RK_VERDICT, 8'h00, 8'h00, ST_TOO_LONG, 16'h0000);
                    wipe();
                end else begin
                    frame_len = int'(len_cap) + FRAME_OVERHEAD;
                end
                return;
            end
            if (idx + 3 < frame_len) begin
                crc_acc = crc_byte(crc_acc, b);
                push(RK_PAYLOAD, b, 8'(idx - HEADER_BYTES), ST_OK, 16'h0000);
            end else if (idx + 3 == frame_len) begin
                crc_hi = b;
            end else if (idx + 2 == frame_len) begin
                crc_lo = b;
            end else begin
                rcrc = {crc_hi, crc_lo};
                if (b != tail_reg)                      st = ST_BAD_TAIL;
                else if (crc_acc != rcrc)               st = ST_CRC_BAD;
                else if (func_byte == DEVICE_ERROR_FUNC) st = ST_DEV_ERR;
                else                                    st = ST_OK;
                push(RK_VERDICT, 8'h00, 8'h00, st, rcrc);
                wipe();
            end
        endfunction

        function void cmp(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $display("%0t: %s expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result act, logic [4:0] pad);
            t_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, act);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            cmp("result_kind", 16'(e.result_kind), 16'(act.result_kind));
            cmp("payload_byte", 16'(e.payload_byte), 16'(act.payload_byte));
            cmp("payload_index", 16'(e.payload_index), 16'(act.payload_index));
            cmp("status", 16'(e.status), 16'(act.status));
            cmp("function_code", 16'(e.function_code), 16'(act.function_code));
            cmp("start_address", e.start_address, act.start_address);
            cmp("data_length", e.data_length, act.data_length);
            cmp("computed_crc", e.computed_crc, act.computed_crc);
            cmp("carried_crc", e.carried_crc, act.carried_crc);
            cmp("tdata_pad", 16'h0000, 16'(pad));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;    // [7:0] rx_byte
    logic               s_axis_tuser = 1'b0;  // [0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status, [26:19] function_code,
    // [42:27] start_address, [58:43] data_length, [74:59] computed_crc,
    // [90:75] carried_crc, [95:91] zero
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;         // [0] result_kind
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    frame_scoreboard sb;
    bit          calm = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned stall_cycles = 0;

    crc_checked_frame_receiver DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // result side: check, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'({m_axis_tuser, m_axis_tdata[90:0]}), m_axis_tdata[95:91]);
        m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // tvalid stays high from one transaction to the next unless a gap is drawn
    task automatic send_item(input t_in_kind k, input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(99) < 18) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(k, b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx r, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == REG_HEAD) sb.head_reg = v;
        else               sb.tail_reg = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] head, input logic [7:0] tail);
        wait_drained();
        reg_write(REG_HEAD, head);
        reg_write(REG_TAIL, tail);
    endtask

    // cut > 0 stops after that many bytes and clears the receiver
    task automatic send_frame(input logic [15:0] dlen, input logic [7:0] func,
                              input bit bad_head, input bit bad_crc, input bit bad_tail,
                              input int unsigned cut);
        logic [7:0]  fb[$];
        logic [15:0] c;
        bit          rejected;
        fb.insert(fb.size(), bad_head ? sb.head_reg ^ 8'($urandom_range(1, 255)) : sb.head_reg);
        fb.insert(fb.size(), 8'($urandom));
        fb.insert(fb.size(), 8'($urandom));
        fb.insert(fb.size(), func);
        fb.insert(fb.size(), 8'($urandom));
        fb.insert(fb.size(), 8'($urandom));
        fb.insert(fb.size(), dlen[15:8]);
        fb.insert(fb.size(), dlen[7:0]);
        rejected = bad_head || (int'(dlen) + FRAME_OVERHEAD > MAX_FRAME_BYTES);
        if (!rejected) begin
            repeat (dlen) fb.insert(fb.size(), 8'($urandom));
            c = 16'hFFFF;
            foreach (fb[i]) c = frame_scoreboard::crc_byte(c, fb[i]);
            if (bad_crc) c ^= 16'($urandom_range(1, 65535));
            fb.insert(fb.size(), c[15:8]);
            fb.insert(fb.size(), c[7:0]);
            fb.insert(fb.size(),
                      bad_tail ? sb.tail_reg ^ 8'($urandom_range(1, 255)) : sb.tail_reg);
        end
        foreach (fb[i]) begin
            if (cut != 0 && i >= cut) break;
            send_item(KIND_BYTE, fb[i]);
        end
        if (cut != 0) send_item(KIND_CLEAR, 8'($urandom));
    endtask

    function automatic logic [15:0] pick_len();
        return ($urandom_range(19) == 0) ? 16'($urandom_range(13, 60))
                                         : 16'($urandom_range(0, 12));
    endfunction

    function automatic logic [7:0] pick_func();
        return ($urandom_range(9) == 0) ? DEVICE_ERROR_FUNC : 8'($urandom);
    endfunction

    task automatic random_frame();
        int unsigned sel;
        logic [15:0] len;
        sel = $urandom_range(99);
        len = pick_len();
        if (sel < 55)
            send_frame(len, pick_func(), 0, 0, 0, 0);
        else if (sel < 62)
            send_frame(len, pick_func(), 0, 0, 1, 0);
        else if (sel < 69)
            send_frame(len, pick_func(), 0, 1, 0, 0);
        else if (sel < 74)
            send_frame(len, pick_func(), 0, 1, 1, 0);
        else if (sel < 79)
            send_frame(len, pick_func(), 1, 0, 0, 0);
        else if (sel < 84)
            send_frame(($urandom_range(1) == 0) ? 16'd246 : 16'($urandom_range(246, 65535)),
                       pick_func(), 0, 0, 0, 0);
        else if (sel < 90)
            send_frame(len, pick_func(), 0, 0, 0, $urandom_range(1, int'(len) + 10));
        else if (sel < 95) begin
            // stray bytes, then realign with a clear
            repeat ($urandom_range(1, 5)) send_item(KIND_BYTE, 8'($urandom));
            send_item(KIND_CLEAR, 8'($urandom));
        end else
            send_frame(len, DEVICE_ERROR_FUNC, 0, 0, 0, 0);
    endtask

    initial begin
        logic [7:0]  heads[4];
        logic [7:0]  tails[4];
        int unsigned target;
        bit          paused;
        sb = new();
        heads = '{8'($urandom), 8'hFF, 8'h00, 8'hFF};
        tails = '{8'($urandom), 8'h00, 8'hFF, 8'hFF};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(8'h00, 8'h00);
        send_frame(16'd2, 8'h01, 0, 0, 0, 3);
        send_frame(16'hFFFF, 8'h03, 0, 0, 0, 0);
        send_frame(16'd0, 8'h03, 1, 0, 0, 0);
        send_frame(16'd0, DEVICE_ERROR_FUNC, 0, 0, 0, 0);

        target = bytes_sent;
        paused = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            configure(heads[ph], tails[ph]);
            calm = (ph == 2);
            if (ph == 2) send_frame(16'd245, pick_func(), 0, 0, 0, 0);
            target += 200;
            while (bytes_sent < target) begin
                if (ph == 0 && !paused && bytes_sent + 100 >= target) begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_frame();
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== crc_checked_frame_receiver.f =====
+incdir+hdl
hdl/ccfr_pkg.sv
hdl/crc_checked_frame_receiver.sv
dv/tb.sv
